/* hw/rtl/scc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the strongly connected components block.
// No dependencies.
package scc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;

  localparam int VW  = 6;                          // vertex number
  localparam int CW  = 7;                          // counts and labels up to 64
  localparam int EAW = $clog2(MAX_EDGES);          // edge table address
  localparam int ECW = $clog2(MAX_EDGES + 1);      // edge count / scan position
  localparam int SW  = VW + ECW;                   // stack entry

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FIND  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_LABEL   = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P1_NEXT,
    S_SCAN_RD,
    S_CHECK,
    S_POP,
    S_RESTORE,
    S_P2_NEXT,
    S_P2_PICK,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_SKIP_V,
    CMD_WALK_START,
    CMD_EDGE_CHECK,
    CMD_POP,
    CMD_RESTORE,
    CMD_P2_INIT,
    CMD_P2_PICK,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic v_done;
    logic v_visited;
    logic scan_end;
    logic depth_last;
    logic pass2;
    logic k_zero;
    logic cand_visited;
    logic emit_last;
  } scc_stat_t;

endpackage

/* hw/rtl/scc_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/scc_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for edge loading, the two depth-first passes and label output.
// Depends on scc_pkg.
module scc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  scc_pkg::op_t      op,
  input  scc_pkg::scc_stat_t stat,
  output scc_pkg::cmd_t     cmd,
  output logic              in_stall
);
  import scc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_stall   = !((state == S_IDLE) && stat.out_free);
    unique case (state)
      S_IDLE: begin
        if (in_valid && stat.out_free) begin
          cmd = CMD_ACCEPT;
          if (op == OP_FIND) state_next = S_P1_NEXT;
        end
      end
      S_P1_NEXT: begin
        if (stat.v_done) begin
          cmd        = CMD_P2_INIT;
          state_next = S_P2_NEXT;
        end else if (stat.v_visited) begin
          cmd = CMD_SKIP_V;
        end else begin
          cmd        = CMD_WALK_START;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = stat.scan_end ? S_POP : S_CHECK;
      end
      S_CHECK: begin
        cmd        = CMD_EDGE_CHECK;
        state_next = S_SCAN_RD;
      end
      S_POP: begin
        cmd = CMD_POP;
        if (stat.depth_last) state_next = stat.pass2 ? S_P2_NEXT : S_P1_NEXT;
        else                 state_next = S_RESTORE;
      end
      S_RESTORE: begin
        cmd        = CMD_RESTORE;
        state_next = S_SCAN_RD;
      end
      S_P2_NEXT: begin
        state_next = stat.k_zero ? S_EMIT_RD : S_P2_PICK;
      end
      S_P2_PICK: begin
        cmd        = CMD_P2_PICK;
        state_next = stat.cand_visited ? S_P2_NEXT : S_SCAN_RD;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd        = CMD_EMIT;
          state_next = stat.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/scc_dp.sv */
`timescale 1ns / 1ps
// Datapath: edge table, visit bits, DFS stack, finish order, labels, result register.
// Depends on scc_pkg and scc_ram.
module scc_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  scc_pkg::cmd_t            cmd,
  output scc_pkg::scc_stat_t       stat,
  input  scc_pkg::op_t             op,
  input  logic [scc_pkg::VW-1:0]   edge_source,
  input  logic [scc_pkg::VW-1:0]   edge_target,
  input  logic                     cfg_we,
  input  logic [scc_pkg::CW-1:0]   cfg_wdata,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [2:0]               status,
  output logic [scc_pkg::VW-1:0]   vertex_id,
  output logic [scc_pkg::CW-1:0]   component_id,
  output logic                     last
);
  import scc_pkg::*;

  logic [CW-1:0]           vertex_count;
  logic [CW-1:0]           n;
  logic [ECW-1:0]          edges_stored;
  logic [MAX_VERTICES-1:0] visited;
  logic [CW-1:0]           finish_count;
  logic [CW-1:0]           depth;
  logic [VW-1:0]           top_v;
  logic [ECW-1:0]          top_e;
  logic [CW-1:0]           vidx;
  logic [CW-1:0]           k;
  logic [CW-1:0]           counter;
  logic                    pass2;

  logic [2*VW-1:0] edge_rd;
  logic [SW-1:0]   stack_rd;
  logic [VW-1:0]   finish_rd;
  logic [CW-1:0]   label_rd;

  logic [VW-1:0] es, et, from_v, to_v;
  logic          edge_ok, hit, push_ok, in_range, tbl_full;
  logic          edge_we, stack_we, finish_we, label_we;
  logic [VW-1:0] label_waddr;
  logic [CW-1:0] label_wdata;
  logic [CW-1:0] depth_m1, depth_m2, k_m1;

  // clamp register to 1..MAX_VERTICES
  always_comb begin
    if (vertex_count == '0)                    n = CW'(1);
    else if (vertex_count > CW'(MAX_VERTICES)) n = CW'(MAX_VERTICES);
    else                                       n = vertex_count;
  end

  assign es      = edge_rd[2*VW-1:VW];
  assign et      = edge_rd[VW-1:0];
  assign from_v  = pass2 ? es : et;
  assign to_v    = pass2 ? et : es;
  assign edge_ok = ({1'b0, es} < n) && ({1'b0, et} < n);
  assign hit     = edge_ok && (from_v == top_v) && !visited[to_v];
  assign push_ok = depth < CW'(MAX_VERTICES);

  assign in_range = ({1'b0, edge_source} < n) && ({1'b0, edge_target} < n);
  assign tbl_full = edges_stored == ECW'(MAX_EDGES);

  assign depth_m1 = depth - CW'(1);
  assign depth_m2 = depth - CW'(2);
  assign k_m1     = k - CW'(1);

  assign edge_we   = (cmd == CMD_ACCEPT) && (op == OP_ADD) && in_range && !tbl_full;
  assign stack_we  = (cmd == CMD_EDGE_CHECK) && hit && push_ok;
  assign finish_we = (cmd == CMD_POP) && !pass2 && (finish_count < CW'(MAX_VERTICES));

  always_comb begin
    label_we    = 1'b0;
    label_waddr = to_v;
    label_wdata = counter;
    if (cmd == CMD_EDGE_CHECK && hit && pass2) begin
      label_we = 1'b1;
    end else if (cmd == CMD_P2_PICK && !visited[finish_rd]) begin
      label_we    = 1'b1;
      label_waddr = finish_rd;
      label_wdata = counter + CW'(1);
    end
  end

  scc_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edges (
    .clk, .we(edge_we), .waddr(edges_stored[EAW-1:0]),
    .wdata({edge_source, edge_target}), .raddr(top_e[EAW-1:0]), .rdata(edge_rd)
  );

  scc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk, .we(stack_we), .waddr(depth_m1[VW-1:0]),
    .wdata({top_v, top_e + ECW'(1)}), .raddr(depth_m2[VW-1:0]), .rdata(stack_rd)
  );

  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_finish (
    .clk, .we(finish_we), .waddr(finish_count[VW-1:0]),
    .wdata(top_v), .raddr(k_m1[VW-1:0]), .rdata(finish_rd)
  );

  scc_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_labels (
    .clk, .we(label_we), .waddr(label_waddr),
    .wdata(label_wdata), .raddr(vidx[VW-1:0]), .rdata(label_rd)
  );

  assign stat.out_free     = !out_valid || !out_stall;
  assign stat.v_done       = vidx == n;
  assign stat.v_visited    = visited[vidx[VW-1:0]];
  assign stat.scan_end     = top_e >= edges_stored;
  assign stat.depth_last   = depth == CW'(1);
  assign stat.pass2        = pass2;
  assign stat.k_zero       = k == '0;
  assign stat.cand_visited = visited[finish_rd];
  assign stat.emit_last    = vidx == n - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CW'(MAX_VERTICES);
      edges_stored <= '0;
      finish_count <= '0;
      depth        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) vertex_count <= cfg_wdata;
      if (cmd == CMD_EMIT || (cmd == CMD_ACCEPT && (op == OP_ADD || op == OP_CLEAR))) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (cmd)
        CMD_ACCEPT: begin
          case (op)
            OP_ADD: begin
              vertex_id    <= '0;
              component_id <= '0;
              last         <= 1'b1;
              if (!in_range)     status <= ST_RANGE;
              else if (tbl_full) status <= ST_FULL;
              else begin
                status       <= ST_STORED;
                edges_stored <= edges_stored + ECW'(1);
              end
            end
            OP_CLEAR: begin
              status       <= ST_CLEARED;
              vertex_id    <= '0;
              component_id <= '0;
              last         <= 1'b1;
              edges_stored <= '0;
            end
            OP_FIND: begin
              visited      <= '0;
              finish_count <= '0;
              vidx         <= '0;
              pass2        <= 1'b0;
            end
            default: ;
          endcase
        end
        CMD_SKIP_V: vidx <= vidx + CW'(1);
        CMD_WALK_START: begin
          visited[vidx[VW-1:0]] <= 1'b1;
          top_v <= vidx[VW-1:0];
          top_e <= '0;
          depth <= CW'(1);
        end
        CMD_EDGE_CHECK: begin
          if (hit) begin
            visited[to_v] <= 1'b1;
            if (push_ok) begin
              top_v <= to_v;
              top_e <= '0;
              depth <= depth + CW'(1);
            end else begin
              top_e <= top_e + ECW'(1);
            end
          end else begin
            top_e <= top_e + ECW'(1);
          end
        end
        CMD_POP: begin
          depth <= depth_m1;
          if (finish_we) finish_count <= finish_count + CW'(1);
        end
        CMD_RESTORE: begin
          top_v <= stack_rd[SW-1:ECW];
          top_e <= stack_rd[ECW-1:0];
        end
        CMD_P2_INIT: begin
          visited <= '0;
          k       <= finish_count;
          counter <= '0;
          pass2   <= 1'b1;
          vidx    <= '0;
        end
        CMD_P2_PICK: begin
          k <= k_m1;
          if (!visited[finish_rd]) begin
            counter            <= counter + CW'(1);
            visited[finish_rd] <= 1'b1;
            top_v              <= finish_rd;
            top_e              <= '0;
            depth              <= CW'(1);
          end
        end
        CMD_EMIT: begin
          status       <= ST_LABEL;
          vertex_id    <= vidx[VW-1:0];
          component_id <= visited[vidx[VW-1:0]] ? label_rd : '0;
          last         <= vidx == n - CW'(1);
          vidx         <= vidx + CW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/strongly_connected_components.sv */
`timescale 1ns / 1ps
// Top level of the strongly connected components block (Kosaraju's method).
// Depends on scc_pkg, scc_ctrl, scc_dp (and scc_ram through scc_dp).
//
// Usage:
//   Input channel (in_valid / in_stall) carries operation, edge_source,
//   edge_target. A beat moves when in_valid is high and in_stall low.
//   Add edge and clear each give one result beat in the cycle after the input
//   beat; a stream of adds runs at one beat per cycle while the receiver
//   keeps up. Operation 3 gives no result.
//   Find holds in_stall high for the whole walk. Each DFS step reads an edge
//   table entry (edge RAM read, then compare), with push and pop steps
//   between scans; each vertex scans the table once per pass. Then, for n
//   vertices, labels come out for vertices 0..n-1 in order, last marked on
//   vertex n-1.
//   Output channel (out_valid / out_stall) is one result register; while the
//   receiver stalls the beat holds and the block waits.
//   cfg_we / cfg_wdata write vertex_count; write only when the block is idle.
//   Reset (rst, synchronous) empties the edge table, sets vertex_count to 64
//   and drops any pending result. No clearing pass is needed.
module strongly_connected_components (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [scc_pkg::CW-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             operation,
  input  logic [scc_pkg::VW-1:0] edge_source,
  input  logic [scc_pkg::VW-1:0] edge_target,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             status,
  output logic [scc_pkg::VW-1:0] vertex_id,
  output logic [scc_pkg::CW-1:0] component_id,
  output logic                   last
);
  import scc_pkg::*;

  cmd_t      cmd;
  scc_stat_t stat;
  op_t       op;

  assign op = op_t'(operation);

  // controller: sequencing only
  scc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .op, .stat, .cmd, .in_stall
  );

  // datapath: storage, compares and the result register
  scc_dp u_dp (
    .clk, .rst, .cmd, .stat, .op, .edge_source, .edge_target,
    .cfg_we, .cfg_wdata, .out_stall, .out_valid, .status,
    .vertex_id, .component_id, .last
  );

endmodule

/* hw/rtl/scc_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for strongly_connected_components, with its bind.
// Depends on scc_pkg and the top level's ports.
module scc_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] operation,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic [6:0] component_id,
  input logic       last
);
  import scc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(last))
    else $error("stalled result beat changed");

  a_add_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation == OP_ADD |=>
      out_valid && last && (status == ST_STORED || status == ST_FULL || status == ST_RANGE))
    else $error("add edge gave no single status beat");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation == OP_CLEAR |=> out_valid && last && status == ST_CLEARED)
    else $error("clear gave no cleared beat");

  a_label_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_LABEL |-> component_id != '0)
    else $error("label beat without a component");

endmodule

bind strongly_connected_components scc_chk u_scc_chk (.*);
